// ===== design/u8u32_pkg.sv =====
// shared types, constants and helpers for the utf-8 to utf-32 decoder
`timescale 1ns / 1ps

package u8u32_pkg;

   // field widths
   localparam int BYTE_W  = 8;
   localparam int CP_W    = 21;
   localparam int COUNT_W = 13;
   localparam int CAP_W   = 14;

   // defaults
   localparam int unsigned MAX_CHARS_DEFAULT = 8192;
   localparam logic [CAP_W-1:0] CAP_RESET    = 14'd8192;
   localparam int unsigned COUNT_MAX         = 8191;

   // sequence length codes (continuation bytes of the current character)
   localparam logic [1:0] SEQ_NONE  = 2'd0;
   localparam logic [1:0] SEQ_TWO   = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR  = 2'd3;

   // shortest-form lower bounds and surrogate range
   localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
   localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
   localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
   localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
   localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;

   // per-string decoder state
   typedef struct packed {
      logic [1:0]         pending;
      logic [1:0]         seq_len;
      logic [CP_W-1:0]    partial;
      logic [COUNT_W-1:0] count;
      logic               err;
   } dec_state_type;

   // one decode step outcome
   typedef struct packed {
      logic               emit;
      logic [CP_W-1:0]    code_point;
      logic               is_end;
      logic [COUNT_W-1:0] char_count;
      logic               status;
   } dec_result_type;

   // characters kept per string for a given buffer size
   function automatic logic [COUNT_W-1:0] char_limit(input logic [CAP_W-1:0] cap,
                                                     input int unsigned max_chars);
      int unsigned c;
      c = 32'(cap);
      if (c > max_chars) c = max_chars;
      if (c == 0) return '0;
      c = c - 1;
      if (c > COUNT_MAX) c = COUNT_MAX;
      return c[COUNT_W-1:0];
   endfunction

endpackage

// ===== design/utf8_to_utf32_decoder.sv =====
// top level: request register, decode step, result register
`timescale 1ns / 1ps

// Streaming UTF-8 to UTF-32 decoder. One byte is taken per request and a zero
// byte ends a string; each completed character within the limit gives one
// result, and the terminator gives an end result with the character count and
// an error flag. The block accepts one byte every cycle while rsp_ready is high;
// a result is registered on its way out: the request register feeds the single
// decode step on the per-string state, which loads the result register, and a
// waiting result holds the step back. The rate of one byte per cycle is set by
// that decode step, which updates the state once per byte. The user must write
// capacity through the csr port only while no request or result is in flight;
// the block itself does not enforce this, and csr writes are always taken.

module utf8_to_utf32_decoder
   import u8u32_pkg::*;
#(
   parameter int unsigned MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CP_W-1:0]    rsp_code_point,
   output logic               rsp_is_end,
   output logic [COUNT_W-1:0] rsp_char_count,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CAP_W-1:0]   csr_capacity
);

   logic               in_valid_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               out_valid_ff;
   dec_result_type     out_ff;
   logic               step_en;
   logic [COUNT_W-1:0] limit;
   dec_result_type     result;

   // configuration
   assign csr_ready = 1'b1;

   u8u32_csr #(
      .MAX_CHARS (MAX_CHARS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (csr_valid & csr_ready),
      .wr_capacity (csr_capacity),
      .limit       (limit)
   );

   // the held byte advances when the result register can take its outcome
   assign step_en   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step_en;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
      end
   end

   u8u32_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .data_byte (in_byte_ff),
      .limit     (limit),
      .result    (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step_en && result.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && result.emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_ff.code_point;
   assign rsp_is_end     = out_ff.is_end;
   assign rsp_char_count = out_ff.char_count;
   assign rsp_status     = out_ff.status;

   // every emitted outcome is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      step_en && result.emit |=> rsp_valid)
      else $error("decoded result not presented");

   // a waiting result is never overwritten by a step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !step_en)
      else $error("decode step while result stalled");

endmodule

// ===== design/u8u32_csr.sv =====
// capacity register, kept as the derived per-string character limit
`timescale 1ns / 1ps

module u8u32_csr
   import u8u32_pkg::*;
#(
   parameter int unsigned MAX_CHARS = MAX_CHARS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [CAP_W-1:0]   wr_capacity,
   output logic [COUNT_W-1:0] limit
);

   logic [COUNT_W-1:0] limit_ff;
   logic [COUNT_W-1:0] limit_in;

   // limit follows the written buffer size
   assign limit_in = char_limit(wr_capacity, MAX_CHARS);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= char_limit(CAP_RESET, MAX_CHARS);
      end else if (wr_en) begin
         limit_ff <= limit_in;
      end
   end

   assign limit = limit_ff;

endmodule

// ===== design/u8u32_decode.sv =====
// per-byte decode step and the per-string decoder state
`timescale 1ns / 1ps

module u8u32_decode
   import u8u32_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic [COUNT_W-1:0] limit,
   output dec_result_type     result
);

   dec_state_type      state_ff;
   dec_state_type      state_in;
   logic [CP_W-1:0]    acc;
   logic [CP_W-1:0]    lowest;
   logic [1:0]         pending_dec;

   // gathered value with this continuation byte appended
   assign acc         = {state_ff.partial[CP_W-7:0], data_byte[5:0]};
   assign pending_dec = state_ff.pending - 2'd1;

   // shortest-form bound for the sequence in progress
   always_comb begin
      case (state_ff.seq_len)
         SEQ_TWO:   lowest = MIN_TWO;
         SEQ_THREE: lowest = MIN_THREE;
         default:   lowest = MIN_FOUR;
      endcase
   end

   // decode one byte
   always_comb begin
      state_in          = state_ff;
      result.emit       = 1'b0;
      result.code_point = '0;
      result.is_end     = 1'b0;
      result.char_count = '0;
      result.status     = 1'b0;
      if (data_byte == '0) begin
         // terminator: report and rearm
         result.emit       = 1'b1;
         result.is_end     = 1'b1;
         result.char_count = state_ff.count;
         result.status     = state_ff.err | (state_ff.pending != 2'd0);
         state_in          = '0;
      end else if (state_ff.err) begin
         // skip until terminator
         state_in = state_ff;
      end else if (state_ff.pending == 2'd0) begin
         if (state_ff.count >= limit) begin
            // buffer full, drop silently
            state_in = state_ff;
         end else if (!data_byte[7]) begin
            result.emit       = 1'b1;
            result.code_point = CP_W'(data_byte);
            state_in.count    = state_ff.count + 1'b1;
         end else if (data_byte[7:5] == 3'b110) begin
            state_in.partial = CP_W'(data_byte[4:0]);
            state_in.pending = 2'd1;
            state_in.seq_len = SEQ_TWO;
         end else if (data_byte[7:4] == 4'b1110) begin
            state_in.partial = CP_W'(data_byte[3:0]);
            state_in.pending = 2'd2;
            state_in.seq_len = SEQ_THREE;
         end else if (data_byte[7:3] == 5'b11110) begin
            state_in.partial = CP_W'(data_byte[2:0]);
            state_in.pending = 2'd3;
            state_in.seq_len = SEQ_FOUR;
         end else begin
            // stray continuation or invalid lead
            state_in.err     = 1'b1;
            state_in.pending = 2'd0;
            state_in.seq_len = SEQ_NONE;
            state_in.partial = '0;
         end
      end else if (data_byte[7:6] != 2'b10) begin
         // bad continuation byte
         state_in.err     = 1'b1;
         state_in.pending = 2'd0;
         state_in.seq_len = SEQ_NONE;
         state_in.partial = '0;
      end else if (pending_dec != 2'd0) begin
         state_in.partial = acc;
         state_in.pending = pending_dec;
      end else begin
         // last continuation byte
         state_in.pending = 2'd0;
         state_in.seq_len = SEQ_NONE;
         state_in.partial = '0;
         if (acc < lowest) begin
            state_in.err = 1'b1;
         end else begin
            result.emit       = 1'b1;
            result.code_point = acc;
            state_in.count    = state_ff.count + 1'b1;
            state_in.err      = (acc >= SURR_LO) && (acc <= SURR_HI);
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

   // a terminator always leaves a clean state
   assert property (@(posedge clock) disable iff (reset)
      step_en && data_byte == '0 |=>
         state_ff.count == '0 && state_ff.pending == 2'd0 && !state_ff.err)
      else $error("decoder state not cleared after terminator");

   // pending continuation bytes never exceed the sequence length
   assert property (@(posedge clock) disable iff (reset)
      state_ff.pending != 2'd0 |->
         state_ff.seq_len != SEQ_NONE && state_ff.pending <= state_ff.seq_len)
      else $error("pending count inconsistent with sequence length");

   // after an error only the terminator gives a result
   assert property (@(posedge clock) disable iff (reset)
      step_en && state_ff.err && data_byte != '0 |-> !result.emit)
      else $error("character emitted after error");

   // an error never coexists with an open sequence
   assert property (@(posedge clock) disable iff (reset)
      state_ff.err |-> state_ff.pending == 2'd0)
      else $error("open sequence while in error");

endmodule
